@@ src/g2g_pkg.sv @@
// shared constants, types and tables of the go-to-goal controller
package g2g_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int AtanTableLen       = 24;

   localparam int PosWidth     = 16;
   localparam int HeadWidth    = 15;
   localparam int RegWidth     = 12;
   localparam int SpeedWidth   = 20;
   localparam int TurnWidth    = 20;
   localparam int CsrIdxWidth  = 2;

   // cordic datapath: 17-bit difference scaled by 2^8, plus growth
   localparam int CordicWidth  = 28;
   localparam int AngleWidth   = 20;
   localparam int SqWidth      = 34;
   localparam int DistWidth    = 17;

   localparam logic signed [AngleWidth-1:0] HalfPiQ16 = 20'sd102944;
   localparam logic signed [AngleWidth-1:0] PiQ12     = 20'sd12868;

   localparam logic [RegWidth-1:0] LinearGainReset  = 12'd256;
   localparam logic [RegWidth-1:0] AngularGainReset = 12'd1536;
   localparam logic [RegWidth-1:0] StopDistReset    = 12'd41;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LINEAR_GAIN  = 2'd0,
      CSR_ANGULAR_GAIN = 2'd1,
      CSR_STOP_DIST    = 2'd2
   } csr_idx_type;

   // atan(2^-i) in q.16, rounded to nearest
   function automatic logic signed [AngleWidth-1:0] atan_q16(input int i);
      logic signed [AngleWidth-1:0] r;
      case (i)
         0:  r = 20'sd51472;
         1:  r = 20'sd30386;
         2:  r = 20'sd16055;
         3:  r = 20'sd8150;
         4:  r = 20'sd4091;
         5:  r = 20'sd2047;
         6:  r = 20'sd1024;
         7:  r = 20'sd512;
         8:  r = 20'sd256;
         9:  r = 20'sd128;
         10: r = 20'sd64;
         11: r = 20'sd32;
         12: r = 20'sd16;
         13: r = 20'sd8;
         14: r = 20'sd4;
         15: r = 20'sd2;
         16: r = 20'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ src/g2g_req_if.sv @@
// input channel: goal point and robot pose
interface g2g_req_if;
   import g2g_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [PosWidth-1:0]         target_x;
   logic [PosWidth-1:0]         target_y;
   logic [PosWidth-1:0]         robot_x;
   logic [PosWidth-1:0]         robot_y;
   logic signed [HeadWidth-1:0] robot_heading;

   modport source (output valid, target_x, target_y, robot_x, robot_y, robot_heading,
                   input ready);
   modport sink   (input valid, target_x, target_y, robot_x, robot_y, robot_heading,
                   output ready);
endinterface

@@ src/g2g_rsp_if.sv @@
// result channel: speed and turn commands
interface g2g_rsp_if;
   import g2g_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [SpeedWidth-1:0]       linear_speed;
   logic signed [TurnWidth-1:0] turn_rate;
   logic                        arrived;

   modport source (output valid, linear_speed, turn_rate, arrived, input ready);
   modport sink   (input valid, linear_speed, turn_rate, arrived, output ready);
endinterface

@@ src/go_to_goal_controller.sv @@
// go-to-goal controller top level: pipelined distance, cordic bearing and gains
//
// Usage: goal and pose items enter on req (valid/ready), one result item
// leaves on rsp per input item, in order. The pipeline takes one item per
// cycle unless rsp stalls; the accepting edge loads the input stage.
// Stages: one input stage, one square/prerotation stage, max(CORDIC_STEPS, 17)
// cordic stages that also run the restoring square root one result bit per
// stage, one rounding stage, one gain stage, one output register. The longer
// of the cordic step count and the 17 root bits sets the depth; throughput is
// one item per clock while rsp is not stalled.
// The whole pipeline advances together; when the receiver holds rsp ready
// low while the output register is full, every stage holds, and req ready
// drops, so nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and loads the gain
// registers with 1.0, 6.0 and a stop distance of 0.01.
// csr writes take effect at once and should only be issued while idle.
module go_to_goal_controller #(
   parameter int CORDIC_STEPS = g2g_pkg::CordicStepsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   g2g_req_if.sink                             req,
   g2g_rsp_if.source                           rsp,
   input  logic                                csr_we,
   input  logic [g2g_pkg::CsrIdxWidth-1:0]     csr_idx,
   input  logic [g2g_pkg::RegWidth-1:0]        csr_wdata
);
   import g2g_pkg::*;

   // root stages: one result bit per stage, 17 bits
   localparam int RootStages = DistWidth;
   localparam int Depth = (CORDIC_STEPS > RootStages) ? CORDIC_STEPS : RootStages;

   typedef struct packed {
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [AngleWidth-1:0]  z;
      logic [SqWidth-1:0]            rem;
      logic [DistWidth-1:0]          root;
      logic                          arrived;
      logic                          zero;
      logic signed [HeadWidth-1:0]   head;
   } stage_type;

   logic [RegWidth-1:0] lin_gain_ff, ang_gain_ff, stop_ff;
   logic advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_gain_ff <= LinearGainReset;
         ang_gain_ff <= AngularGainReset;
         stop_ff     <= StopDistReset;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_LINEAR_GAIN:  lin_gain_ff <= csr_wdata;
            CSR_ANGULAR_GAIN: ang_gain_ff <= csr_wdata;
            CSR_STOP_DIST:    stop_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 0: register input
   logic v0_ff;
   logic signed [DistWidth-1:0] dx0_ff, dy0_ff;
   logic signed [HeadWidth-1:0] hd0_ff;

   // stage 1: squares, arrival test, quadrant prerotation
   logic v1_ff;
   stage_type s1_ff;

   // cordic / root stages
   logic      vc_ff [Depth];
   stage_type sc_ff [Depth];

   // rounding stage
   logic v2_ff;
   logic [DistWidth-1:0] dist2_ff;
   logic signed [AngleWidth-1:0] err2_ff;
   logic arr2_ff;

   // gain stage
   logic v3_ff;
   logic [DistWidth+RegWidth-1:0] spd3_ff;
   logic signed [AngleWidth+RegWidth:0] trn3_ff;
   logic arr3_ff;

   // output register
   logic out_v_ff;
   logic [SpeedWidth-1:0] out_spd_ff;
   logic signed [TurnWidth-1:0] out_trn_ff;
   logic out_arr_ff;

   assign advance   = !out_v_ff || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (advance) v0_ff <= req.valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         dx0_ff <= $signed({1'b0, req.target_x}) - $signed({1'b0, req.robot_x});
         dy0_ff <= $signed({1'b0, req.target_y}) - $signed({1'b0, req.robot_y});
         hd0_ff <= req.robot_heading;
      end
   end

   // stage 1 logic
   stage_type s1_in;
   logic signed [SqWidth-1:0] dxsq, dysq;
   logic [SqWidth-1:0] sq1;
   logic [2*RegWidth-1:0] stop_sq;
   logic signed [CordicWidth-1:0] xs, ys;
   always_comb begin
      dxsq = dx0_ff * dx0_ff;
      dysq = dy0_ff * dy0_ff;
      sq1 = $unsigned(dxsq) + $unsigned(dysq);
      stop_sq = stop_ff * stop_ff;
      xs = CordicWidth'(dx0_ff) <<< 8;
      ys = CordicWidth'(dy0_ff) <<< 8;
      s1_in = '0;
      s1_in.rem = sq1;
      s1_in.root = '0;
      s1_in.arrived = sq1 < SqWidth'(stop_sq);
      s1_in.zero = (dx0_ff == '0) && (dy0_ff == '0);
      s1_in.head = hd0_ff;
      s1_in.x = xs;
      s1_in.y = ys;
      s1_in.z = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            s1_in.x = ys; s1_in.y = -xs; s1_in.z = HalfPiQ16;
         end else begin
            s1_in.x = -ys; s1_in.y = xs; s1_in.z = -HalfPiQ16;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= v0_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) s1_ff <= s1_in;
   end

   // cordic and restoring square root stages
   stage_type sc_in [Depth];
   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         stage_type p;
         logic signed [CordicWidth-1:0] sx, sy;
         logic [SqWidth-1:0] trial;
         int b;
         sx = '0;
         sy = '0;
         trial = '0;
         b = 0;
         p = (i == 0) ? s1_ff : sc_ff[i-1];
         sc_in[i] = p;
         if (i < CORDIC_STEPS) begin
            sx = p.x >>> i;
            sy = p.y >>> i;
            if (p.y >= 0) begin
               sc_in[i].x = p.x + sy; sc_in[i].y = p.y - sx;
               sc_in[i].z = p.z + atan_q16(i);
            end else begin
               sc_in[i].x = p.x - sy; sc_in[i].y = p.y + sx;
               sc_in[i].z = p.z - atan_q16(i);
            end
         end
         if (i < RootStages) begin
            b = RootStages - 1 - i;
            // trial = (2*root*2^b + 2^2b) with root holding upper bits
            trial = (SqWidth'(p.root) << (b + 1)) + (SqWidth'(1) << (2 * b));
            if (p.rem >= trial) begin
               sc_in[i].rem  = p.rem - trial;
               sc_in[i].root = p.root | (DistWidth'(1) << b);
            end
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) vc_ff[i] <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < Depth; i++) vc_ff[i] <= (i == 0) ? v1_ff : vc_ff[i-1];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < Depth; i++) sc_ff[i] <= sc_in[i];
      end
   end

   // rounding of angle and heading error
   stage_type sl;
   logic signed [AngleWidth-1:0] zr, bear;
   assign sl = sc_ff[Depth-1];
   always_comb begin
      zr = (sl.z + $signed(AngleWidth'(8))) >>> 4;
      if (zr > PiQ12) bear = PiQ12;
      else if (zr < -PiQ12) bear = -PiQ12;
      else bear = zr;
      if (sl.zero) bear = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= vc_ff[Depth-1];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         dist2_ff <= sl.root;
         err2_ff  <= bear - AngleWidth'(sl.head);
         arr2_ff  <= sl.arrived;
      end
   end

   // gain multiplies
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         spd3_ff <= lin_gain_ff * dist2_ff;
         trn3_ff <= $signed({1'b0, ang_gain_ff}) * err2_ff;
         arr3_ff <= arr2_ff;
      end
   end

   // round, saturate, output register
   logic [DistWidth+RegWidth-1:0] spd_r;
   logic signed [AngleWidth+RegWidth:0] trn_r;
   logic [SpeedWidth-1:0] spd_o;
   logic signed [TurnWidth-1:0] trn_o;
   always_comb begin
      spd_r = (spd3_ff + (DistWidth+RegWidth)'(128)) >> 8;
      trn_r = (trn3_ff + $signed((AngleWidth+RegWidth+1)'(128))) >>> 8;
      spd_o = (spd_r > (DistWidth+RegWidth)'({SpeedWidth{1'b1}}))
              ? {SpeedWidth{1'b1}} : SpeedWidth'(spd_r);
      if (trn_r > $signed((AngleWidth+RegWidth+1)'(524287))) trn_o = 20'sd524287;
      else if (trn_r < -$signed((AngleWidth+RegWidth+1)'(524288))) trn_o = 20'sh80000;
      else trn_o = TurnWidth'(trn_r);
      if (arr3_ff) begin
         spd_o = '0;
         trn_o = '0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (advance) out_v_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         out_spd_ff <= spd_o;
         out_trn_ff <= trn_o;
         out_arr_ff <= arr3_ff;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.linear_speed = out_spd_ff;
   assign rsp.turn_rate    = out_trn_ff;
   assign rsp.arrived      = out_arr_ff;

endmodule
